### src/yfra_pkg.sv
package yfra_pkg;

    localparam int unsigned MAX_FRAME_SAMPLES = 4194304;
    localparam int unsigned COUNT_W           = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int unsigned PIX_W             = 8;
    localparam int unsigned SKIP_W            = 5;
    localparam int unsigned PHASE_W           = 4;
    localparam int unsigned SUM_W             = 32;
    localparam int unsigned AVG_W             = 10;
    localparam int unsigned COLOUR_W          = 11;
    localparam int unsigned PROD_W            = 19;
    localparam int unsigned DIV_STEPS         = SUM_W;
    localparam int unsigned STEP_W            = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W         = 1;

    localparam logic [SKIP_W-1:0]    SKIP_RESET = SKIP_W'(2);
    localparam logic [SKIP_W-1:0]    SKIP_MAX   = SKIP_W'(16);
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_Y = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef struct packed {
        logic  accept;
        logic  div_load;
        logic  div_step;
        logic  div_store;
        logic  load_out;
        chan_t ch;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // zero acts as one, anything above sixteen as sixteen
    function automatic logic [SKIP_W-1:0] eff_skip(input logic [SKIP_W-1:0] s);
        logic [SKIP_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SKIP_W'(1);
        end else if (s > SKIP_MAX) begin
            r = SKIP_MAX;
        end
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] advance_phase(input logic [PHASE_W-1:0] phase,
                                                         input logic [SKIP_W-1:0] skip);
        logic [SKIP_W-1:0] nxt;
        nxt = {1'b0, phase} + SKIP_W'(1);
        return (nxt >= skip) ? '0 : nxt[PHASE_W-1:0];
    endfunction

endpackage

### src/yfra_datapath.sv
module yfra_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [yfra_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [yfra_pkg::SKIP_W-1:0]           cfg_data,
    input  logic [yfra_pkg::PIX_W-1:0]            s_luma,
    input  logic [yfra_pkg::PIX_W-1:0]            s_chroma_u,
    input  logic [yfra_pkg::PIX_W-1:0]            s_chroma_v,
    input  logic                                  s_end_of_line,
    input  yfra_pkg::dp_cmd_t                     cmd,
    output yfra_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_red_average,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_green_average,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_blue_average,
    output logic [yfra_pkg::COUNT_W-1:0]          m_kept_count
);

    logic [yfra_pkg::SKIP_W-1:0]          skip_x_reg, skip_y_reg;
    logic [yfra_pkg::PHASE_W-1:0]         col_phase_reg, row_phase_reg;
    logic [yfra_pkg::COUNT_W-1:0]         total_reg;
    logic                                 keep;

    logic signed [8:0]                    u_s, v_s;
    logic signed [yfra_pkg::PROD_W-1:0]   r_prod, g_prod, b_prod;
    logic signed [yfra_pkg::COLOUR_W-1:0] r_pix, g_pix, b_pix, y_s;

    logic                                 pix_valid_reg;
    logic signed [yfra_pkg::COLOUR_W-1:0] r_pix_reg, g_pix_reg, b_pix_reg;
    logic signed [yfra_pkg::SUM_W-1:0]    red_sum_reg, green_sum_reg, blue_sum_reg;

    logic signed [yfra_pkg::SUM_W-1:0]    sel_sum;
    logic [yfra_pkg::SUM_W-1:0]           quo_reg;
    logic [yfra_pkg::COUNT_W-1:0]         rem_reg;
    logic                                 neg_reg;
    logic [yfra_pkg::COUNT_W:0]           rem_shift;
    logic                                 ge;
    logic [yfra_pkg::AVG_W-1:0]           quo_signed;

    logic signed [yfra_pkg::AVG_W-1:0]    red_avg_reg, green_avg_reg, blue_avg_reg;
    logic                                 m_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_x_reg <= yfra_pkg::SKIP_RESET;
            skip_y_reg <= yfra_pkg::SKIP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                yfra_pkg::CFG_SKIP_X: skip_x_reg <= cfg_data;
                yfra_pkg::CFG_SKIP_Y: skip_y_reg <= cfg_data;
            endcase
        end
    end

    assign keep = (col_phase_reg == '0) && (row_phase_reg == '0) &&
                  (total_reg < yfra_pkg::COUNT_W'(yfra_pkg::MAX_FRAME_SAMPLES));

    // phases and count advance at the transfer; colours are registered at the transfer and summed from those registers
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            total_reg     <= '0;
        end else if (cmd.accept) begin
            total_reg <= total_reg + yfra_pkg::COUNT_W'(keep);
            if (s_end_of_line) begin
                col_phase_reg <= '0;
                row_phase_reg <= yfra_pkg::advance_phase(row_phase_reg,
                                                         yfra_pkg::eff_skip(skip_y_reg));
            end else begin
                col_phase_reg <= yfra_pkg::advance_phase(col_phase_reg,
                                                         yfra_pkg::eff_skip(skip_x_reg));
            end
        end
    end

    assign u_s    = signed'({1'b0, s_chroma_u}) - 9'sd128;
    assign v_s    = signed'({1'b0, s_chroma_v}) - 9'sd128;
    assign r_prod = yfra_pkg::PROD_W'(v_s) * 19'sd351;
    assign g_prod = yfra_pkg::PROD_W'(v_s) * 19'sd179 + yfra_pkg::PROD_W'(u_s) * 19'sd86;
    assign b_prod = yfra_pkg::PROD_W'(u_s) * 19'sd443;
    assign y_s    = signed'({3'b000, s_luma});
    assign r_pix  = y_s + yfra_pkg::COLOUR_W'(r_prod >>> 8);
    assign g_pix  = y_s - yfra_pkg::COLOUR_W'(g_prod >>> 8);
    assign b_pix  = y_s + yfra_pkg::COLOUR_W'(b_prod >>> 8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else begin
            pix_valid_reg <= cmd.accept && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            r_pix_reg <= r_pix;
            g_pix_reg <= g_pix;
            b_pix_reg <= b_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
        end else if (pix_valid_reg) begin
            red_sum_reg   <= red_sum_reg + yfra_pkg::SUM_W'(r_pix_reg);
            green_sum_reg <= green_sum_reg + yfra_pkg::SUM_W'(g_pix_reg);
            blue_sum_reg  <= blue_sum_reg + yfra_pkg::SUM_W'(b_pix_reg);
        end
    end

    // restoring divider, one quotient bit per step, shared by the three sums
    always_comb begin
        unique case (cmd.ch)
            yfra_pkg::CH_RED:   sel_sum = red_sum_reg;
            yfra_pkg::CH_GREEN: sel_sum = green_sum_reg;
            yfra_pkg::CH_BLUE:  sel_sum = blue_sum_reg;
            default:            sel_sum = '0;
        endcase
    end

    assign rem_shift  = {rem_reg, quo_reg[yfra_pkg::SUM_W-1]};
    assign ge         = rem_shift >= {1'b0, total_reg};
    assign quo_signed = neg_reg ? (yfra_pkg::AVG_W'(0) - quo_reg[yfra_pkg::AVG_W-1:0])
                                : quo_reg[yfra_pkg::AVG_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            neg_reg <= sel_sum[yfra_pkg::SUM_W-1];
            quo_reg <= sel_sum[yfra_pkg::SUM_W-1] ? unsigned'(-sel_sum) : unsigned'(sel_sum);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? yfra_pkg::COUNT_W'(rem_shift - {1'b0, total_reg})
                          : rem_shift[yfra_pkg::COUNT_W-1:0];
            quo_reg <= {quo_reg[yfra_pkg::SUM_W-2:0], ge};
        end
    end

    // an empty frame averages to zero
    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            unique case (cmd.ch)
                yfra_pkg::CH_RED:   red_avg_reg   <= (total_reg == '0) ? '0 : signed'(quo_signed);
                yfra_pkg::CH_GREEN: green_avg_reg <= (total_reg == '0) ? '0 : signed'(quo_signed);
                yfra_pkg::CH_BLUE:  blue_avg_reg  <= (total_reg == '0) ? '0 : signed'(quo_signed);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= cmd.load_out || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_red_average   <= red_avg_reg;
            m_green_average <= green_avg_reg;
            m_blue_average  <= blue_avg_reg;
            m_kept_count    <= total_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= yfra_pkg::COUNT_W'(yfra_pkg::MAX_FRAME_SAMPLES))
        else $error("kept count beyond frame limit");
    a_no_accept_mid_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step || cmd.div_load) |-> !cmd.accept && !pix_valid_reg)
        else $error("pixel transfer while dividing");
`endif

endmodule

### src/yfra_ctrl.sv
module yfra_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_end_of_frame,
    output yfra_pkg::dp_cmd_t    cmd,
    input  yfra_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        S_RUN,
        S_DRAIN,
        S_LOAD,
        S_STEP,
        S_STORE,
        S_OUT
    } state_t;

    state_t                        state_reg;
    logic                          s_ready_reg;
    yfra_pkg::chan_t               ch_reg;
    logic [yfra_pkg::STEP_W-1:0]   step_reg;
    logic                          accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    assign cmd.accept    = accept;
    assign cmd.div_load  = (state_reg == S_LOAD);
    assign cmd.div_step  = (state_reg == S_STEP);
    assign cmd.div_store = (state_reg == S_STORE);
    assign cmd.load_out  = (state_reg == S_OUT) && status.out_free;
    assign cmd.ch        = ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            s_ready_reg <= 1'b1;
            ch_reg      <= yfra_pkg::CH_RED;
            step_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_RUN: begin
                    if (accept && s_end_of_frame) begin
                        state_reg   <= S_DRAIN;
                        s_ready_reg <= 1'b0;
                    end
                end
                S_DRAIN: begin
                    ch_reg    <= yfra_pkg::CH_RED;
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    step_reg <= step_reg + yfra_pkg::STEP_W'(1);
                    if (step_reg == yfra_pkg::STEP_W'(yfra_pkg::DIV_STEPS - 1)) begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    unique case (ch_reg)
                        yfra_pkg::CH_RED: begin
                            ch_reg    <= yfra_pkg::CH_GREEN;
                            state_reg <= S_LOAD;
                        end
                        yfra_pkg::CH_GREEN: begin
                            ch_reg    <= yfra_pkg::CH_BLUE;
                            state_reg <= S_LOAD;
                        end
                        default: begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (status.out_free) begin
                        state_reg   <= S_RUN;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_eof_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_frame) |=> !s_ready)
        else $error("input still open after end of frame");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an untaken result");
    a_reopen_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> s_ready && (state_reg == S_RUN))
        else $error("input not reopened after result load");
    a_ready_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_RUN))
        else $error("input open outside run state");
`endif

endmodule

### src/yuv_frame_rgb_average.sv
// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  cfg_index (0 skip_x, 1 skip_y), cfg_data
// s (in)    s_valid/s_ready      s_luma, s_chroma_u, s_chroma_v, s_end_of_line,
//                                s_end_of_frame
// m (out)   m_valid/m_ready      m_red_average, m_green_average, m_blue_average,
//                                m_kept_count
//
// One pixel transfer per cycle within a frame; colours are summed in the cycle after the transfer.
// After the end-of-frame pixel the input closes while the averages are computed: one shared
// restoring divider produces one quotient bit per cycle for each colour, in turn.
// A result waiting on m_ready holds the input closed only when the next frame ends first.
// Reset is synchronous, active low; skip registers return to 2, sums and phases to zero.
// Configuration transfers are always taken (cfg_ready held high).
module yuv_frame_rgb_average (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [yfra_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [yfra_pkg::SKIP_W-1:0]           cfg_data,
    // pixel stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [yfra_pkg::PIX_W-1:0]            s_luma,
    input  logic [yfra_pkg::PIX_W-1:0]            s_chroma_u,
    input  logic [yfra_pkg::PIX_W-1:0]            s_chroma_v,
    input  logic                                  s_end_of_line,
    input  logic                                  s_end_of_frame,
    // frame averages
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_red_average,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_green_average,
    output logic signed [yfra_pkg::AVG_W-1:0]     m_blue_average,
    output logic [yfra_pkg::COUNT_W-1:0]          m_kept_count
);

    // controller drives commands, datapath reports whether the result register is free
    yfra_pkg::dp_cmd_t    cmd;
    yfra_pkg::dp_status_t status;

    yfra_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_end_of_frame (s_end_of_frame),
        .cmd            (cmd),
        .status         (status)
    );

    // skip configuration, phases, pixel conversion, sums, divider and result register
    yfra_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_luma          (s_luma),
        .s_chroma_u      (s_chroma_u),
        .s_chroma_v      (s_chroma_v),
        .s_end_of_line   (s_end_of_line),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_average   (m_red_average),
        .m_green_average (m_green_average),
        .m_blue_average  (m_blue_average),
        .m_kept_count    (m_kept_count)
    );

endmodule
